// File: rtl/dltq_pkg.sv
// package: sizes, codes and shared types of the delta-list timer queue
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int PROCESS_ID_BITS = 8;
  localparam int MAX_RESULTS     = 16;
  localparam int DELTA_W         = 32;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NCNT_W = $clog2(MAX_RESULTS + 1);

  // input kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // result kinds
  localparam logic [1:0] RES_EXPIRED = 2'd0;
  localparam logic [1:0] RES_FULL    = 2'd1;
  localparam logic [1:0] RES_CANCEL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_DEC,
    S_T_CHECK,
    S_T_POP,
    S_A_WALK,
    S_A_SHIFT,
    S_A_INS,
    S_A_FIX,
    S_C_WALK
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [DELTA_W-1:0]   a;
    logic [DELTA_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [DELTA_W-1:0]   res;
    logic                 flag;   // carry out on add, borrow on sub
    logic                 zero;
  } alu_rsp_t;

  typedef struct packed {
    logic                       we;
    logic [IDX_W-1:0]           addr;
    logic [DELTA_W-1:0]         delta;
    logic [PROCESS_ID_BITS-1:0] pid;
  } store_wr_t;

  typedef struct packed {
    logic [DELTA_W-1:0]         rd_delta;
    logic [PROCESS_ID_BITS-1:0] rd_pid;
    logic [DELTA_W-1:0]         head0_delta;
    logic [PROCESS_ID_BITS-1:0] head0_pid;
    logic [DELTA_W-1:0]         head1_delta;
  } store_rd_t;

endpackage
`default_nettype wire

// File: rtl/dltq_alu.sv
// shared 32-bit add/subtract unit with carry/borrow and zero flags
`timescale 1ns / 1ps
`default_nettype none
module dltq_alu
  import dltq_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [DELTA_W:0] wide;

  always_comb begin
    if (req.op == ALU_SUB) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.res  = wide[DELTA_W-1:0];
    rsp.flag = wide[DELTA_W];
    rsp.zero = (wide[DELTA_W-1:0] == '0);
  end

endmodule
`default_nettype wire

// File: rtl/dltq_store.sv
// entry register file: one write port, one indexed read port, fixed head taps
`timescale 1ns / 1ps
`default_nettype none
module dltq_store
  import dltq_pkg::*;
(
  input  logic             clk,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] rd_addr,
  output store_rd_t        rd
);

  logic [DELTA_W-1:0]         delta_r [QUEUE_DEPTH];
  logic [PROCESS_ID_BITS-1:0] pid_r   [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      delta_r[wr.addr] <= wr.delta;
      pid_r[wr.addr]   <= wr.pid;
    end
  end

  always_comb begin
    rd.rd_delta    = delta_r[rd_addr];
    rd.rd_pid      = pid_r[rd_addr];
    rd.head0_delta = delta_r[0];
    rd.head0_pid   = pid_r[0];
    rd.head1_delta = delta_r[1];
  end

endmodule
`default_nettype wire

// File: rtl/dltq_seq.sv
// sequencer: walks the entry store one slot per cycle, doing delta arithmetic in the shared unit
`timescale 1ns / 1ps
`default_nettype none
module dltq_seq
  import dltq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_process_id,
  input  logic [31:0]          in_delay,
  output logic                 busy,
  output alu_req_t             alu_req,
  input  alu_rsp_t             alu_rsp,
  output store_wr_t            st_wr,
  output logic [IDX_W-1:0]     st_rd_addr,
  input  store_rd_t            st_rd,
  output logic                 out_strobe,
  output logic [1:0]           out_result_kind,
  output logic [7:0]           out_process_id_res,
  output logic [4:0]           out_removed_count,
  output logic                 out_last
);

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           p_r, p_nxt;       // walk position / cancel read index
  logic [CNT_W-1:0]           i_r, i_nxt;       // shift index
  logic [CNT_W-1:0]           w_r, w_nxt;       // cancel write index
  logic [CNT_W-1:0]           removed_r, removed_nxt;
  logic [NCNT_W-1:0]          n_r, n_nxt;       // expiries this tick
  logic [DELTA_W-1:0]         rem_r, rem_nxt;
  logic [DELTA_W-1:0]         carry_r, carry_nxt;
  logic [PROCESS_ID_BITS-1:0] pid_r, pid_nxt;

  logic                       strobe_r, strobe_nxt;
  logic [1:0]                 rkind_r, rkind_nxt;
  logic [7:0]                 rpid_r, rpid_nxt;
  logic [4:0]                 rcnt_r, rcnt_nxt;
  logic                       rlast_r, rlast_nxt;

  logic [CNT_W-1:0]           i_dec, p_inc;

  assign i_dec = i_r - CNT_W'(1);
  assign p_inc = p_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    w_r       <= w_nxt;
    removed_r <= removed_nxt;
    n_r       <= n_nxt;
    rem_r     <= rem_nxt;
    carry_r   <= carry_nxt;
    pid_r     <= pid_nxt;
    rkind_r   <= rkind_nxt;
    rpid_r    <= rpid_nxt;
    rcnt_r    <= rcnt_nxt;
    rlast_r   <= rlast_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    p_nxt       = p_r;
    i_nxt       = i_r;
    w_nxt       = w_r;
    removed_nxt = removed_r;
    n_nxt       = n_r;
    rem_nxt     = rem_r;
    carry_nxt   = carry_r;
    pid_nxt     = pid_r;
    strobe_nxt  = 1'b0;
    rkind_nxt   = rkind_r;
    rpid_nxt    = rpid_r;
    rcnt_nxt    = rcnt_r;
    rlast_nxt   = rlast_r;

    alu_req.op  = ALU_SUB;
    alu_req.a   = rem_r;
    alu_req.b   = st_rd.rd_delta;
    st_wr.we    = 1'b0;
    st_wr.addr  = p_r[IDX_W-1:0];
    st_wr.delta = alu_rsp.res;
    st_wr.pid   = pid_r;
    st_rd_addr  = p_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pid_nxt = PROCESS_ID_BITS'(in_process_id);
          rem_nxt = in_delay;
          p_nxt   = '0;
          w_nxt   = '0;
          n_nxt   = '0;
          unique case (in_kind)
            KIND_TICK: begin
              if (count_r != '0) begin
                state_nxt = S_T_DEC;
              end
            end
            KIND_ADD: begin
              if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                strobe_nxt = 1'b1;
                rkind_nxt  = RES_FULL;
                rpid_nxt   = 8'(PROCESS_ID_BITS'(in_process_id));
                rcnt_nxt   = '0;
                rlast_nxt  = 1'b1;
              end else begin
                state_nxt = S_A_WALK;
              end
            end
            KIND_CANCEL: begin
              carry_nxt   = '0;
              removed_nxt = '0;
              state_nxt   = S_C_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      // saturating decrement of the head delta
      S_T_DEC: begin
        alu_req.op  = ALU_SUB;
        alu_req.a   = st_rd.head0_delta;
        alu_req.b   = DELTA_W'(1);
        st_wr.addr  = '0;
        st_wr.pid   = st_rd.head0_pid;
        st_wr.we    = (st_rd.head0_delta != '0);
        state_nxt   = S_T_CHECK;
      end

      S_T_CHECK: begin
        if (count_r != '0 && st_rd.head0_delta == '0 &&
            n_r != NCNT_W'(MAX_RESULTS)) begin
          strobe_nxt = 1'b1;
          rkind_nxt  = RES_EXPIRED;
          rpid_nxt   = 8'(st_rd.head0_pid);
          rcnt_nxt   = '0;
          rlast_nxt  = (count_r == CNT_W'(1)) || (st_rd.head1_delta != '0) ||
                       (n_r == NCNT_W'(MAX_RESULTS - 1));
          n_nxt      = n_r + NCNT_W'(1);
          i_nxt      = CNT_W'(1);
          state_nxt  = S_T_POP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // shift entries down by one over the popped head
      S_T_POP: begin
        st_rd_addr = i_r[IDX_W-1:0];
        if (i_r < count_r) begin
          st_wr.we    = 1'b1;
          st_wr.addr  = i_dec[IDX_W-1:0];
          st_wr.delta = st_rd.rd_delta;
          st_wr.pid   = st_rd.rd_pid;
          i_nxt       = i_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_T_CHECK;
        end
      end

      // find the insert slot, subtracting deltas passed over
      S_A_WALK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = rem_r;
        alu_req.b  = st_rd.rd_delta;
        if (p_r < count_r && !alu_rsp.flag && !alu_rsp.zero) begin
          rem_nxt = alu_rsp.res;
          p_nxt   = p_inc;
        end else begin
          i_nxt     = count_r;
          state_nxt = S_A_SHIFT;
        end
      end

      // open a hole at the insert slot, from the tail down
      S_A_SHIFT: begin
        st_rd_addr = i_dec[IDX_W-1:0];
        if (i_r > p_r) begin
          st_wr.we    = 1'b1;
          st_wr.addr  = i_r[IDX_W-1:0];
          st_wr.delta = st_rd.rd_delta;
          st_wr.pid   = st_rd.rd_pid;
          i_nxt       = i_dec;
        end else begin
          state_nxt = S_A_INS;
        end
      end

      S_A_INS: begin
        st_wr.we    = 1'b1;
        st_wr.addr  = p_r[IDX_W-1:0];
        st_wr.delta = rem_r;
        st_wr.pid   = pid_r;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = (p_r < count_r) ? S_A_FIX : S_IDLE;
      end

      // the follower loses the new entry's delta
      S_A_FIX: begin
        st_rd_addr  = p_inc[IDX_W-1:0];
        alu_req.op  = ALU_SUB;
        alu_req.a   = st_rd.rd_delta;
        alu_req.b   = rem_r;
        st_wr.we    = 1'b1;
        st_wr.addr  = p_inc[IDX_W-1:0];
        st_wr.delta = alu_rsp.res;
        st_wr.pid   = st_rd.rd_pid;
        state_nxt   = S_IDLE;
      end

      // compact the queue, folding removed deltas into the next survivor
      S_C_WALK: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = st_rd.rd_delta;
        alu_req.b  = carry_r;
        if (p_r < count_r) begin
          if (st_rd.rd_pid == pid_r) begin
            carry_nxt   = alu_rsp.res;
            removed_nxt = removed_r + CNT_W'(1);
          end else begin
            st_wr.we    = 1'b1;
            st_wr.addr  = w_r[IDX_W-1:0];
            st_wr.delta = alu_rsp.res;
            st_wr.pid   = st_rd.rd_pid;
            carry_nxt   = '0;
            w_nxt       = w_r + CNT_W'(1);
          end
          p_nxt = p_inc;
        end else begin
          count_nxt  = w_r;
          strobe_nxt = 1'b1;
          rkind_nxt  = RES_CANCEL;
          rpid_nxt   = 8'(pid_r);
          rcnt_nxt   = 5'(removed_r);
          rlast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = strobe_r;
  assign out_result_kind    = rkind_r;
  assign out_process_id_res = rpid_r;
  assign out_removed_count  = rcnt_r;
  assign out_last           = rlast_r;

endmodule
`default_nettype wire

// File: rtl/delta_list_timer_queue.sv
// top level of the delta-list timer queue
//
//   channel   ports                                          transaction taken when
//   -------   --------------------------------------------   ----------------------
//   input     start, busy, in_kind, in_process_id, in_delay   start && !busy
//   result    out_strobe, out_result_kind,                    every cycle out_strobe
//             out_process_id_res, out_removed_count, out_last is high
//
// one transaction at a time; busy stays high while the sequencer walks the store
// one slot per cycle; a tick on an empty queue, an unknown kind and an add on a full
// queue never raise busy
// reset clears the state and the entry count; entry contents need no clearing
// each result is registered and shows for one cycle; the receiver cannot stall them
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_process_id,
  input  logic [31:0] in_delay,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_process_id_res,
  output logic [4:0]  out_removed_count,
  output logic        out_last
);

  // shared arithmetic unit traffic
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // entry store ports
  store_wr_t        st_wr;
  store_rd_t        st_rd;
  logic [IDX_W-1:0] st_rd_addr;

  dltq_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_kind            (in_kind),
    .in_process_id      (in_process_id),
    .in_delay           (in_delay),
    .busy               (busy),
    .alu_req            (alu_req),
    .alu_rsp            (alu_rsp),
    .st_wr              (st_wr),
    .st_rd_addr         (st_rd_addr),
    .st_rd              (st_rd),
    .out_strobe         (out_strobe),
    .out_result_kind    (out_result_kind),
    .out_process_id_res (out_process_id_res),
    .out_removed_count  (out_removed_count),
    .out_last           (out_last)
  );

  // one adder/subtractor serves the walk compare, the delta fixups and cancel folding
  dltq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // deltas and process ids, head taps feed tick handling directly
  dltq_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_rd_addr),
    .rd      (st_rd)
  );

endmodule
`default_nettype wire

// File: rtl/dltq_checker.sv
// port-level checker for the delta-list timer queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dltq_checker
  import dltq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_strobe,
  input logic [1:0] out_result_kind,
  input logic [4:0] out_removed_count,
  input logic       out_last
);

  // a cancel always walks the store before reporting
  a_cancel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_CANCEL) |=> busy)
    else $error("cancel accepted without going busy");

  // a rejected add is a single-result transaction
  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == RES_FULL) |-> out_last)
    else $error("full report not marked last");

  // a cancel report is a single-result transaction
  a_cancel_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind == RES_CANCEL) |-> out_last)
    else $error("cancel report not marked last");

  // only cancel reports carry a removal count
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_kind != RES_CANCEL) |-> (out_removed_count == '0))
    else $error("removal count on a non-cancel result");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_kind           (in_kind),
  .out_strobe        (out_strobe),
  .out_result_kind   (out_result_kind),
  .out_removed_count (out_removed_count),
  .out_last          (out_last)
);
`default_nettype wire

// File: dv/delta_list_timer_queue_checker.sv
// checker for the delta-list timer queue: shadow queue, expected results and compare
`timescale 1ns / 1ps
module delta_list_timer_queue_checker
  import dltq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_process_id,
  input  logic [31:0] in_delay,
  input  logic        out_strobe,
  input  logic [1:0]  out_result_kind,
  input  logic [7:0]  out_process_id_res,
  input  logic [4:0]  out_removed_count,
  input  logic        out_last,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pid;
    logic [4:0] removed;
    logic       last;
  } timer_event_t;

  // shadow copy of the delta list; counters start at zero as two-state ints
  logic [DELTA_W-1:0]         slot_delta [QUEUE_DEPTH];
  logic [PROCESS_ID_BITS-1:0] slot_pid   [QUEUE_DEPTH];
  int                         live;

  timer_event_t               expected_events [$];

  function automatic void push_event(input logic [1:0] kind, input logic [7:0] pid,
                                     input logic [4:0] removed, input logic last);
    timer_event_t ev;
    ev.kind    = kind;
    ev.pid     = pid;
    ev.removed = removed;
    ev.last    = last;
    expected_events.push_back(ev);
  endfunction

  function automatic void expire_on_tick();
    int           fired;
    timer_event_t tail;
    fired = 0;
    if (live == 0) return;
    if (slot_delta[0] != '0) slot_delta[0] = slot_delta[0] - 1'b1;
    while (live > 0 && slot_delta[0] == '0 && fired < MAX_RESULTS) begin
      push_event(RES_EXPIRED, 8'(slot_pid[0]), 5'd0, 1'b0);
      fired++;
      for (int i = 1; i < live; i++) begin
        slot_delta[i-1] = slot_delta[i];
        slot_pid[i-1]   = slot_pid[i];
      end
      live--;
    end
    if (fired > 0) begin
      tail      = expected_events.pop_back();
      tail.last = 1'b1;
      expected_events.push_back(tail);
    end
  endfunction

  function automatic void insert_timer(input logic [PROCESS_ID_BITS-1:0] pid,
                                       input logic [DELTA_W-1:0] delay);
    int                 pos;
    logic [DELTA_W-1:0] rest;
    if (live >= QUEUE_DEPTH) begin
      push_event(RES_FULL, 8'(pid), 5'd0, 1'b1);
      return;
    end
    pos  = 0;
    rest = delay;
    while (pos < live && slot_delta[pos] < rest) begin
      rest = rest - slot_delta[pos];
      pos++;
    end
    for (int i = live; i > pos; i--) begin
      slot_delta[i] = slot_delta[i-1];
      slot_pid[i]   = slot_pid[i-1];
    end
    slot_delta[pos] = rest;
    slot_pid[pos]   = pid;
    live++;
    if (pos + 1 < live) slot_delta[pos+1] = slot_delta[pos+1] - rest;
  endfunction

  function automatic void cancel_process(input logic [PROCESS_ID_BITS-1:0] pid);
    int                 kept;
    int                 dropped;
    logic [DELTA_W-1:0] carry;
    kept    = 0;
    dropped = 0;
    carry   = '0;
    for (int r = 0; r < live; r++) begin
      if (slot_pid[r] == pid) begin
        carry = carry + slot_delta[r];
        dropped++;
      end else begin
        slot_delta[kept] = slot_delta[r] + carry;
        slot_pid[kept]   = slot_pid[r];
        carry            = '0;
        kept++;
      end
    end
    live = kept;
    push_event(RES_CANCEL, 8'(pid), 5'(dropped), 1'b1);
  endfunction

  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n) begin
      // results first: a result never belongs to a transaction taken at this edge
      if (out_strobe) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: result_kind %0d process_id_res %0d",
                 out_result_kind, out_process_id_res);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, out_result_kind);
            mismatch_count++;
          end
          if (out_process_id_res !== want.pid) begin
            $error("process_id_res: expected %0d, actual %0d", want.pid,
                   out_process_id_res);
            mismatch_count++;
          end
          if (out_removed_count !== want.removed) begin
            $error("removed_count: expected %0d, actual %0d", want.removed,
                   out_removed_count);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        case (in_kind)
          KIND_TICK:   expire_on_tick();
          KIND_ADD:    insert_timer(in_process_id[PROCESS_ID_BITS-1:0], in_delay);
          KIND_CANCEL: cancel_process(in_process_id[PROCESS_ID_BITS-1:0]);
          default:     ;
        endcase
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// File: dv/delta_list_timer_queue_tb.sv
// testbench top for the delta-list timer queue: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module delta_list_timer_queue_tb;
  import dltq_pkg::*;

  // the one kind code the block has no use for
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS = 250;
  // worst tick: up to depth expiries, each of which shifts the rest of the store down
  localparam int DRAIN_CYCLES = 400;
  localparam int SETTLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [7:0]  in_process_id;
  logic [31:0] in_delay;
  logic        out_strobe;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_process_id_res;
  logic [4:0]  out_removed_count;
  logic        out_last;

  int mismatch_count;
  int outstanding;

  // sender gaps on or off; off for one long stretch of the random part
  bit gaps_on;

  always #6 clk = ~clk;

  delta_list_timer_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_process_id      (in_process_id),
    .in_delay           (in_delay),
    .out_strobe         (out_strobe),
    .out_result_kind    (out_result_kind),
    .out_process_id_res (out_process_id_res),
    .out_removed_count  (out_removed_count),
    .out_last           (out_last)
  );

  delta_list_timer_queue_checker timer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_process_id      (in_process_id),
    .in_delay           (in_delay),
    .out_strobe         (out_strobe),
    .out_result_kind    (out_result_kind),
    .out_process_id_res (out_process_id_res),
    .out_removed_count  (out_removed_count),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  // one transaction: optional idle cycles with junk payload, then hold start
  // until the block takes it (start high, busy low at the edge); each idle
  // step lasts until an edge where the block was ready, so gaps are real
  task automatic issue(input logic [1:0] kind, input logic [7:0] pid,
                       input logic [31:0] delay);
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      start         <= 1'b0;
      in_kind       <= 2'($urandom);
      in_process_id <= 8'($urandom);
      in_delay      <= $urandom;
      do @(posedge clk); while (busy);
    end
    start         <= 1'b1;
    in_kind       <= kind;
    in_process_id <= pid;
    in_delay      <= delay;
    // busy is read before this edge's updates land, so it is the value at the edge
    do @(posedge clk); while (busy);
  endtask

  // random transaction; fill phases lean on adds, drain phases on ticks
  task automatic issue_random(input bit filling);
    int          pick;
    logic [1:0]  kind;
    logic [7:0]  pid;
    logic [31:0] delay;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      kind = KIND_RESERVED;
    else if (pick < 20)
      kind = KIND_CANCEL;
    else if (filling)
      kind = (pick < 75) ? KIND_ADD : KIND_TICK;
    else
      kind = (pick < 40) ? KIND_ADD : KIND_TICK;
    // a small id pool so cancels find matches, now and then any id
    pid  = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60)
      delay = $urandom_range(0, 4);
    else if (pick < 80)
      delay = $urandom_range(0, 100);
    else if (pick < 95)
      delay = $urandom;
    else
      delay = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    issue(kind, pid, delay);
  endtask

  initial begin
    int waited;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_kind       <= KIND_TICK;
    in_process_id <= 8'd0;
    in_delay      <= 32'd0;
    gaps_on        = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue corners
    issue(KIND_TICK, 8'd0, 32'd0);                      // tick on an empty queue
    issue(KIND_CANCEL, 8'd0, 32'd0);                    // cancel finds nothing
    issue(KIND_RESERVED, 8'hFF, 32'hFFFF_FFFF);         // unknown kind is ignored

    // zero-delay adds go ahead of zero deltas and fire on a saturated head
    issue(KIND_ADD, 8'hFF, 32'hFFFF_FFFF);
    issue(KIND_ADD, 8'h00, 32'd0);
    issue(KIND_ADD, 8'hAA, 32'd0);
    issue(KIND_TICK, 8'd0, 32'd0);

    // fill to depth, a rejected add, then one tick that expires almost all of it
    for (int i = 1; i < QUEUE_DEPTH; i++) issue(KIND_ADD, 8'(i), 32'd1);
    issue(KIND_ADD, 8'h55, 32'd7);
    issue(KIND_TICK, 8'd0, 32'd0);
    // removing the tail drops its delta
    issue(KIND_CANCEL, 8'hFF, 32'd0);

    // random part, with one long stretch of back-to-back transactions
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 90 && n < 160);
      issue_random(((n / 40) % 2) == 0);
    end
    start <= 1'b0;

    // let every expected result arrive; outstanding is read away from the edge
    waited = 0;
    @(negedge clk);
    while (outstanding != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      // catch anything the block emits beyond what was expected
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (mismatch_count == 0 && outstanding == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
      $finish;
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
